// ===== rtl/generational_handle_table_core_defines.svh =====
// Assertion macros shared by the handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define GHT_ASSERT_IMP(label, ck, rn, ante, cons)
`define GHT_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/ght_pkg.sv =====
// Types, codes and default sizes of the generational handle table.
package ght_pkg;

    localparam int SLOT_COUNT_DEF = 256;
    localparam int GEN_BITS_DEF   = 16;

    localparam int KIND_W = 3;
    localparam int IDX_W  = 8;
    localparam int HGEN_W = 16;
    localparam int LIVE_W = 9;
    localparam int REV_W  = 32;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOUCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_EXEC,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_CLR_DONE
    } ght_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  handle_index;
        logic [HGEN_W-1:0] handle_generation;
    } ght_req_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  out_index;
        logic [HGEN_W-1:0] out_generation;
        logic [LIVE_W-1:0] live_count;
        logic [REV_W-1:0]  object_revision;
        logic [REV_W-1:0]  transform_revision;
    } ght_rsp_t;

endpackage

// ===== rtl/generational_handle_table_core.sv =====
// Check, touch, free and allocate go from idle through execute; an allocate from the free
// stack adds a pop state first. Requests are taken only in idle, so none is taken before the
// last has left execute. Clear walks each used slot through a read and a write state.
// Reset: asynchronous, active low; clears counters, control and the response valid flag.
// Slot memory is never cleared: entries at or above the high-water mark count as free
// and get generation one on first allocation, so no clearing pass is needed after reset.
`include "generational_handle_table_core_defines.svh"

module generational_handle_table_core
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ght_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ght_rsp_t rsp
);

    // Address width of both memories and width of the slot counters, which must
    // hold SLOT_COUNT itself.
    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int XW    = CW + IDX_W;
    localparam int CMP_W = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

    // Add one to a generation, skipping zero so that a zero handle never matches.
    function automatic logic [GEN_BITS-1:0] bump_gen(input logic [GEN_BITS-1:0] g);
        logic [GEN_BITS-1:0] n;
        begin
            n = g + GEN_BITS'(1);
            bump_gen = (n == '0) ? GEN_BITS'(1) : n;
        end
    endfunction

    // Slot memory word: occupied flag on top of the generation.
    logic [GEN_BITS:0] slot_mem [SLOT_COUNT];
    logic [AW-1:0]     stack_mem [SLOT_COUNT];

    logic [GEN_BITS:0] slot_rd_reg;
    logic [AW-1:0]     stack_rd_reg;

    logic              slot_re;
    logic [AW-1:0]     slot_ra;
    logic              slot_we;
    logic [AW-1:0]     slot_wa;
    logic [GEN_BITS:0] slot_wd;
    logic              stack_re;
    logic [AW-1:0]     stack_ra;
    logic              stack_we;
    logic [AW-1:0]     stack_wa;
    logic [AW-1:0]     stack_wd;

    ght_state_t state_reg, state_next;
    ght_req_t   req_reg, req_next;
    logic [CW-1:0]    depth_reg, depth_next;
    logic [CW-1:0]    mark_reg, mark_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [REV_W-1:0] orev_reg, orev_next;
    logic [REV_W-1:0] trev_reg, trev_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    ght_rsp_t         rsp_reg, rsp_next;

    logic                accept;
    logic                out_free;
    logic                handle_hit;
    logic [CW-1:0]       stack_top;
    logic                clr_last;
    logic [GEN_BITS-1:0] rd_gen;
    logic                rd_occ;

    // A transaction enters only in idle; the output register lets the next request
    // be taken while the previous response is still stalled downstream.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rd_gen    = slot_rd_reg[GEN_BITS-1:0];
    assign rd_occ    = slot_rd_reg[GEN_BITS];
    assign stack_top = depth_reg - CW'(1);
    assign clr_last  = ((CW'(ptr_reg) + CW'(1)) == mark_reg);

    // A handle is valid when its generation is nonzero, its index lies below the
    // high-water mark, and the slot is occupied with a matching generation.
    assign handle_hit = (req_reg.handle_generation != '0)
                     && (XW'(req_reg.handle_index) < XW'(mark_reg))
                     && rd_occ
                     && (CMP_W'(rd_gen) == CMP_W'(req_reg.handle_generation));

    // Both memories have one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.kind == KIND_ALLOC) && (depth_reg != '0))
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    if ((req_reg.kind == KIND_CLEAR) && (count_reg != '0))
                    begin
                        state_next = ST_CLR_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLR_RD:
            begin
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                state_next = clr_last ? ST_CLR_DONE : ST_CLR_RD;
            end
            ST_CLR_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory ports and response logic.
    always_comb
    begin
        req_next       = req_reg;
        depth_next     = depth_reg;
        mark_next      = mark_reg;
        count_next     = count_reg;
        orev_next      = orev_reg;
        trev_next      = trev_reg;
        ptr_next       = ptr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        slot_re  = 1'b0;
        slot_ra  = AW'(req.handle_index);
        slot_we  = 1'b0;
        slot_wa  = ptr_reg;
        slot_wd  = '0;
        stack_re = 1'b0;
        stack_ra = stack_top[AW-1:0];
        stack_we = 1'b0;
        stack_wa = ptr_reg;
        stack_wd = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Read the addressed slot and the top of the free stack at once.
                if (accept)
                begin
                    req_next = req;
                    slot_re  = 1'b1;
                    stack_re = 1'b1;
                end
            end
            ST_POP:
            begin
                slot_re = 1'b1;
                slot_ra = stack_rd_reg;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_next.ok             = 1'b0;
                    rsp_next.out_index      = '0;
                    rsp_next.out_generation = '0;
                    rsp_valid_next          = 1'b1;
                    case (req_reg.kind)
                        KIND_ALLOC:
                        begin
                            if (depth_reg != '0)
                            begin
                                // Reuse the slot on top of the free stack.
                                depth_next              = stack_top;
                                slot_we                 = 1'b1;
                                slot_wa                 = stack_rd_reg;
                                slot_wd                 = {1'b1, rd_gen};
                                rsp_next.ok             = 1'b1;
                                rsp_next.out_index      = IDX_W'(stack_rd_reg);
                                rsp_next.out_generation = HGEN_W'(rd_gen);
                            end
                            else if (mark_reg != CW'(SLOT_COUNT))
                            begin
                                // A never-used slot is given generation one.
                                mark_next               = mark_reg + CW'(1);
                                slot_we                 = 1'b1;
                                slot_wa                 = mark_reg[AW-1:0];
                                slot_wd                 = {1'b1, GEN_BITS'(1)};
                                rsp_next.ok             = 1'b1;
                                rsp_next.out_index      = IDX_W'(mark_reg);
                                rsp_next.out_generation = HGEN_W'(1);
                            end
                            if (rsp_next.ok)
                            begin
                                count_next = count_reg + CW'(1);
                                orev_next  = orev_reg + REV_W'(1);
                                trev_next  = trev_reg + REV_W'(1);
                            end
                        end
                        KIND_FREE:
                        begin
                            if (handle_hit)
                            begin
                                slot_we = 1'b1;
                                slot_wa = AW'(req_reg.handle_index);
                                slot_wd = {1'b0, bump_gen(rd_gen)};
                                if (depth_reg != CW'(SLOT_COUNT))
                                begin
                                    stack_we   = 1'b1;
                                    stack_wa   = depth_reg[AW-1:0];
                                    stack_wd   = AW'(req_reg.handle_index);
                                    depth_next = depth_reg + CW'(1);
                                end
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                orev_next   = orev_reg + REV_W'(1);
                                trev_next   = trev_reg + REV_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        KIND_CHECK:
                        begin
                            rsp_next.ok = handle_hit;
                        end
                        KIND_TOUCH:
                        begin
                            if (handle_hit)
                            begin
                                trev_next   = trev_reg + REV_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            // With live slots the answer waits for the walk.
                            rsp_next.ok = 1'b1;
                            if (count_reg != '0)
                            begin
                                ptr_next       = '0;
                                rsp_valid_next = rsp_valid_reg && rsp_stall;
                            end
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    rsp_next.live_count         = LIVE_W'(count_next);
                    rsp_next.object_revision    = orev_next;
                    rsp_next.transform_revision = trev_next;
                end
            end
            ST_CLR_RD:
            begin
                slot_re = 1'b1;
                slot_ra = ptr_reg;
            end
            ST_CLR_WR:
            begin
                // Vacate the slot and rebuild the free stack in index order.
                slot_we  = 1'b1;
                slot_wa  = ptr_reg;
                slot_wd  = {1'b0, rd_occ ? bump_gen(rd_gen) : rd_gen};
                stack_we = 1'b1;
                stack_wa = ptr_reg;
                stack_wd = ptr_reg;
                ptr_next = ptr_reg + AW'(1);
            end
            ST_CLR_DONE:
            begin
                if (out_free)
                begin
                    depth_next     = mark_reg;
                    count_next     = '0;
                    orev_next      = orev_reg + REV_W'(1);
                    trev_next      = trev_reg + REV_W'(1);
                    rsp_valid_next = 1'b1;
                    rsp_next.ok                 = 1'b1;
                    rsp_next.out_index          = '0;
                    rsp_next.out_generation     = '0;
                    rsp_next.live_count         = '0;
                    rsp_next.object_revision    = orev_next;
                    rsp_next.transform_revision = trev_next;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            mark_reg      <= '0;
            count_reg     <= '0;
            orev_reg      <= '0;
            trev_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            orev_reg      <= orev_next;
            trev_reg      <= trev_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
    end

    // Every used slot is either live or on the free stack.
    `GHT_ASSERT_IMP(a_slot_balance, clk, rst_n, 1'b1, (count_reg + depth_reg) == mark_reg)
    // An accepted transaction blocks the request channel in the following cycle.
    `GHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, req_stall)
    // The clear walk never writes at or above the high-water mark.
    `GHT_ASSERT_IMP(a_walk_in_range, clk, rst_n, state_reg == ST_CLR_WR, CW'(ptr_reg) < mark_reg)

endmodule
